/* sv/tase_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the tile animation slot engine.
// Request and result payloads, the slot descriptor word, and the
// controller/datapath command and status groups. No dependencies.
package tase_pkg;

  // Defaults of the top level parameters.
  localparam int unsigned NUM_SLOTS_DEF        = 16;
  localparam int unsigned MAX_ROWS_DEF         = 32;
  localparam int unsigned ROW_STRIDE_WORDS_DEF = 128;

  // Reset value of the tile buffer base register.
  localparam logic [31:0] BUFFER_BASE_RST = 32'h0200_6000;

  // Request command codes.
  localparam logic [1:0] CMD_LOAD      = 2'd0;
  localparam logic [1:0] CMD_LOAD_LOOP = 2'd1;
  localparam logic [1:0] CMD_STEP      = 2'd2;

  // Result kinds.
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_ROW = 1'b1;

  // Slot flag bits.
  localparam int unsigned FLAG_ONESHOT = 0;
  localparam int unsigned FLAG_PAUSED  = 1;

  // Bank 2 lies this many address bits above bank 1.
  localparam int unsigned BANK_SHIFT = 15;

  // Frame data starts this many bytes after the descriptor.
  localparam logic [31:0] DESC_BYTES = 32'd8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot;
    logic        bank_bit;
    logic [7:0]  flags;
    logic [7:0]  frame_count;
    logic [3:0]  speed_shift;
    logic [7:0]  tile_x;
    logic [7:0]  tile_y;
    logic [7:0]  frame_width;
    logic [5:0]  frame_height;
    logic [31:0] desc_address;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] next_desc_address;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [7:0]  word_count;
    logic        last;
  } rsp_t;

  // One slot descriptor as kept in the slot memory.
  typedef struct packed {
    logic [7:0]  flags;
    logic [7:0]  frames;
    logic [3:0]  shift;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  width;
    logic [5:0]  height;
    logic [15:0] ticks;
    logic [31:0] source;
  } desc_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // capture request, read slot
    logic load_store; // write loaded descriptor
    logic mul_wh;     // width * height, destination base
    logic mul_fr;     // times frame count or frame number
    logic step_eval;  // advance ticks, write back
    logic calc_src;   // first row source
    logic emit_ack;   // load acknowledgement into output register
    logic emit_row;   // row copy command into output register
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_load;
    logic in_step;
    logic in_slot_ok;
    logic step_go;
    logic out_free;
    logic last_row;
  } dp_sts_t;

endpackage

/* sv/tase_req_if.sv */
`timescale 1ns / 1ps
// Request channel of the tile animation slot engine: valid, ready, payload.
// Depends on tase_pkg.
interface tase_req_if;
  import tase_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/tase_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel of the tile animation slot engine: valid, ready, payload.
// Depends on tase_pkg.
interface tase_rsp_if;
  import tase_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/tase_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tase_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tase_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the tile animation slot engine: sequences loads and steps.
// Depends on tase_pkg; drives tase_dp through ctl_cmd_t.
module tase_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  tase_pkg::dp_sts_t  sts_i,
  output tase_pkg::ctl_cmd_t cmd_o
);
  import tase_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LMUL1 = 4'd1;
  localparam logic [3:0] S_LMUL2 = 4'd2;
  localparam logic [3:0] S_LACK  = 4'd3;
  localparam logic [3:0] S_SEVAL = 4'd4;
  localparam logic [3:0] S_SMUL1 = 4'd5;
  localparam logic [3:0] S_SMUL2 = 4'd6;
  localparam logic [3:0] S_SADD  = 4'd7;
  localparam logic [3:0] S_ROWS  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_load) begin
            state_d = S_LMUL1;
          end else if (sts_i.in_step && sts_i.in_slot_ok) begin
            state_d = S_SEVAL;
          end
        end
      end
      S_LMUL1: begin
        cmd_o.load_store = 1'b1;
        cmd_o.mul_wh     = 1'b1;
        state_d          = S_LMUL2;
      end
      S_LMUL2: begin
        cmd_o.mul_fr = 1'b1;
        state_d      = S_LACK;
      end
      S_LACK: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ack = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SEVAL: begin
        cmd_o.step_eval = 1'b1;
        state_d         = sts_i.step_go ? S_SMUL1 : S_IDLE;
      end
      S_SMUL1: begin
        cmd_o.mul_wh = 1'b1;
        state_d      = S_SMUL2;
      end
      S_SMUL2: begin
        cmd_o.mul_fr = 1'b1;
        state_d      = S_SADD;
      end
      S_SADD: begin
        cmd_o.calc_src = 1'b1;
        state_d        = S_ROWS;
      end
      S_ROWS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_row = 1'b1;
          if (sts_i.last_row) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/tase_dp.sv */
`timescale 1ns / 1ps
// Datapath of the tile animation slot engine: slot store, bank bits,
// multipliers, address counters and the output register.
// Depends on tase_pkg and tase_ram; commanded by tase_ctrl.
module tase_dp #(
  parameter int unsigned NUM_SLOTS        = tase_pkg::NUM_SLOTS_DEF,
  parameter int unsigned MAX_ROWS         = tase_pkg::MAX_ROWS_DEF,
  parameter int unsigned ROW_STRIDE_WORDS = tase_pkg::ROW_STRIDE_WORDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tase_pkg::ctl_cmd_t cmd_i,
  output tase_pkg::dp_sts_t  sts_o,
  input  tase_pkg::req_t     req_data_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output tase_pkg::rsp_t     rsp_data_o
);
  import tase_pkg::*;

  localparam int unsigned SW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam logic [RW-1:0] MAX_ROWS_C   = RW'(MAX_ROWS);
  localparam logic [31:0]   STRIDE_BYTES = 32'(ROW_STRIDE_WORDS * 2);

  logic [31:0]   buf_base_q;
  logic [1:0]    bank_q [NUM_SLOTS];
  logic [1:0]    bank_rd_q;
  logic [SW-1:0] slot_idx_q;
  logic          slot_ok_q;
  logic          is_loop_q;
  logic          is_step_q;
  logic          bank_bit_q;
  desc_t         cur_q;
  logic [7:0]    frame_q;
  logic [RW-1:0] rows_q;
  logic [RW-1:0] row_q;
  logic [13:0]   prod_wh_q;
  logic [21:0]   prod_q;
  logic [31:0]   src_q;
  logic [31:0]   dst_q;
  logic          rsp_valid_q;
  rsp_t          rsp_q;

  logic [SW-1:0] in_idx;
  desc_t         rd_desc;
  desc_t         ld_desc;
  desc_t         st_desc;
  desc_t         wr_desc;
  logic [15:0]   ticks_inc;
  logic [15:0]   frame_full;
  logic [15:0]   loop_ticks;
  logic          wrap;
  logic          active;
  logic          retire;
  logic [RW-1:0] rows_new;
  logic          load_we;
  logic          step_we;
  logic [31:0]   sum_src;
  logic [7:0]    mul_op;

  assign in_idx = SW'(req_data_i.slot);

  // Status toward the controller.
  assign sts_o.in_load    = (req_data_i.cmd == CMD_LOAD) || (req_data_i.cmd == CMD_LOAD_LOOP);
  assign sts_o.in_step    = (req_data_i.cmd == CMD_STEP);
  assign sts_o.in_slot_ok = (32'(req_data_i.slot) < NUM_SLOTS);
  assign sts_o.out_free   = !rsp_valid_q || rsp_ready_i;
  assign sts_o.last_row   = ((row_q + RW'(1)) == rows_q);

  // Step evaluation on the descriptor just read.
  assign ticks_inc  = rd_desc.ticks + 16'd1;
  assign frame_full = ticks_inc >> rd_desc.shift;
  assign wrap       = frame_full >= {8'd0, rd_desc.frames};
  assign active     = (bank_rd_q != 2'd0) && !rd_desc.flags[FLAG_PAUSED];
  assign retire     = wrap && rd_desc.flags[FLAG_ONESHOT];
  assign rows_new   = (32'(rd_desc.height) > MAX_ROWS) ? MAX_ROWS_C : RW'(rd_desc.height);
  assign sts_o.step_go = active && !retire && (rd_desc.height != 6'd0);

  // Write-port data for loads and for tick write-back.
  assign loop_ticks = (16'(cur_q.frames) << cur_q.shift) - 16'd2;
  always_comb begin
    ld_desc       = cur_q;
    ld_desc.ticks = is_loop_q ? loop_ticks : 16'd0;
    st_desc       = rd_desc;
    st_desc.ticks = wrap ? 16'd0 : ticks_inc;
    wr_desc       = cmd_i.load_store ? ld_desc : st_desc;
  end

  assign load_we = cmd_i.load_store && slot_ok_q;
  assign step_we = cmd_i.step_eval && active;

  tase_ram #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (load_we || step_we),
    .waddr_i (slot_idx_q),
    .wdata_i (wr_desc),
    .re_i    (cmd_i.accept),
    .raddr_i (in_idx),
    .rdata_o (rd_desc)
  );

  assign sum_src = cur_q.source + (32'(prod_q) << 1);
  assign mul_op  = is_step_q ? frame_q : cur_q.frames;

  // Control state: config register, slot banks (zero is idle), output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_base_q  <= BUFFER_BASE_RST;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        bank_q[i] <= 2'd0;
      end
    end else begin
      if (cfg_we_i) begin
        buf_base_q <= cfg_wdata_i;
      end
      if (load_we) begin
        bank_q[slot_idx_q] <= {1'b0, bank_bit_q} + 2'd1;
      end else if (step_we && retire) begin
        bank_q[slot_idx_q] <= 2'd0;
      end
      if (cmd_i.emit_ack || cmd_i.emit_row) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      slot_idx_q    <= in_idx;
      slot_ok_q     <= sts_o.in_slot_ok;
      is_loop_q     <= (req_data_i.cmd == CMD_LOAD_LOOP);
      is_step_q     <= sts_o.in_step;
      bank_bit_q    <= req_data_i.bank_bit;
      bank_rd_q     <= bank_q[in_idx];
      cur_q.flags   <= req_data_i.flags;
      cur_q.frames  <= req_data_i.frame_count;
      cur_q.shift   <= req_data_i.speed_shift;
      cur_q.x       <= req_data_i.tile_x;
      cur_q.y       <= req_data_i.tile_y;
      cur_q.width   <= req_data_i.frame_width;
      cur_q.height  <= req_data_i.frame_height;
      cur_q.ticks   <= 16'd0;
      cur_q.source  <= req_data_i.desc_address + DESC_BYTES;
    end
    if (cmd_i.step_eval) begin
      cur_q   <= rd_desc;
      frame_q <= wrap ? 8'd0 : frame_full[7:0];
      rows_q  <= rows_new;
    end
    if (cmd_i.mul_wh) begin
      prod_wh_q <= 14'(cur_q.width) * 14'(cur_q.height);
      dst_q     <= buf_base_q + (32'(bank_rd_q - 2'd1) << BANK_SHIFT)
                   + {16'd0, cur_q.y, 8'd0} + {23'd0, cur_q.x, 1'b0};
    end
    if (cmd_i.mul_fr) begin
      prod_q <= 22'(prod_wh_q) * 22'(mul_op);
    end
    if (cmd_i.calc_src) begin
      src_q <= sum_src;
      row_q <= '0;
    end
    if (cmd_i.emit_row) begin
      src_q <= src_q + {23'd0, cur_q.width, 1'b0};
      dst_q <= dst_q + STRIDE_BYTES;
      row_q <= row_q + RW'(1);
    end
    if (cmd_i.emit_ack) begin
      rsp_q.kind              <= KIND_ACK;
      rsp_q.next_desc_address <= sum_src;
      rsp_q.src_address       <= 32'd0;
      rsp_q.dst_address       <= 32'd0;
      rsp_q.word_count        <= 8'd0;
      rsp_q.last              <= 1'b1;
    end else if (cmd_i.emit_row) begin
      rsp_q.kind              <= KIND_ROW;
      rsp_q.next_desc_address <= 32'd0;
      rsp_q.src_address       <= src_q;
      rsp_q.dst_address       <= dst_q;
      rsp_q.word_count        <= cur_q.width;
      rsp_q.last              <= sts_o.last_row;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o  = rsp_q;

endmodule

/* sv/tile_animation_slot_engine_unit.sv */
`timescale 1ns / 1ps
// Top level of the tile animation slot engine.
// Depends on tase_pkg, tase_req_if, tase_rsp_if, tase_ctrl, tase_dp, tase_ram.
//
// Usage:
//   req_i carries one request per valid/ready handshake: a descriptor load
//   (plain or looped counter start) or a step of one slot. rsp_o returns the
//   results: one acknowledgement per load, holding the address after the
//   descriptor's frame data, or one row copy command per frame row per step.
//   The last result of a request has last set. cfg_we_i/cfg_wdata_i write
//   the tile buffer base; write it only while no request is in flight.
// Timing: one request at a time.
//   A load runs the descriptor store and both multiplies before its result
//   enters the output register. A step runs the slot memory read, tick
//   update, two multiplier steps and source add, then one row per cycle while
//   the output register is free, up to MAX_ROWS rows. An idle, paused,
//   one-shot-retiring or zero-height step frees the block after the tick
//   update. Shared 8x6 and 14x8 multipliers and the slot memory port set these.
// Reset: all slots idle, buffer base back to its default; slot contents are
//   undefined until loaded. A stalled receiver holds the output register and
//   the row sequence waits; nothing is dropped.
module tile_animation_slot_engine_unit #(
  parameter int unsigned NUM_SLOTS        = tase_pkg::NUM_SLOTS_DEF,
  parameter int unsigned MAX_ROWS         = tase_pkg::MAX_ROWS_DEF,
  parameter int unsigned ROW_STRIDE_WORDS = tase_pkg::ROW_STRIDE_WORDS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tase_req_if.sink     req_i,
  tase_rsp_if.source   rsp_o,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i
);
  import tase_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;
  logic     req_ready;

  // Sequence each request.
  tase_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (dp_sts),
    .cmd_o       (ctl_cmd)
  );

  // Hold slots, compute addresses, drive the output register.
  tase_dp #(
    .NUM_SLOTS        (NUM_SLOTS),
    .MAX_ROWS         (MAX_ROWS),
    .ROW_STRIDE_WORDS (ROW_STRIDE_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctl_cmd),
    .sts_o       (dp_sts),
    .req_data_i  (req_i.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_o.data)
  );

  assign req_i.ready = req_ready;

`ifndef SYNTH
  // Never overwrite a result the receiver has not taken.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_cmd.emit_ack || ctl_cmd.emit_row) |-> dp_sts.out_free)
    else $error("result emitted over a pending result");

  // Datapath operations other than the descriptor store are mutually exclusive.
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_cmd.accept, ctl_cmd.mul_wh, ctl_cmd.mul_fr, ctl_cmd.step_eval,
              ctl_cmd.calc_src, ctl_cmd.emit_ack, ctl_cmd.emit_row}))
    else $error("overlapping datapath operations");

  // No new request while a step is evaluated, a row is emitted or a load is acknowledged.
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_cmd.step_eval || ctl_cmd.emit_row || ctl_cmd.emit_ack) |-> !req_i.ready)
    else $error("request taken while busy");

  // A load acknowledgement shows up next cycle as the final result.
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.emit_ack |=> (rsp_o.valid && rsp_o.data.last && (rsp_o.data.kind == KIND_ACK)))
    else $error("load acknowledgement missing");
`endif

endmodule
